[src/gaussian_2d_likelihood_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian likelihood block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_2D_LIKELIHOOD_ASSERT_SVH
`define GAUSSIAN_2D_LIKELIHOOD_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define G2L_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define G2L_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/g2l_pkg.sv]
// ----------------------------------------------------------------------------
// g2l_pkg
// Widths, constants, register indexes and shared types of the bivariate
// Gaussian likelihood pipeline.
// ----------------------------------------------------------------------------
package g2l_pkg;

  // Field and datapath widths.
  localparam int MEAN_W     = 16;
  localparam int COV_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DET_W      = 63;
  localparam int MAG_W      = 67;
  localparam int QUO_W      = 43;
  localparam int LV_W       = 48;
  localparam int DENS_W     = 32;

  // Divider geometry: integer quotient bits below the cap, then fraction bits.
  localparam int DIV_INT_STEPS  = 10;
  localparam int DIV_FRAC_STEPS = 32;
  localparam int DIV_STEPS      = DIV_INT_STEPS + DIV_FRAC_STEPS;
  localparam int REM_W          = DET_W + DIV_INT_STEPS;

  // Series evaluation of 2^f.
  localparam int TAYLOR_TERMS = 16;
  localparam int RECIP_SHIFT  = 35;
  localparam int SH_MAX       = 40;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COV_XX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COV_XY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COV_YX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COV_YY = 3'd5;

  // Fixed-point constants.
  localparam logic [31:0] LN2_Q32        = 32'hB17217F8;
  localparam logic [31:0] HALF_LOG2E_Q32 = 32'hB8AA3B29;
  localparam logic [31:0] PI_Q30         = 32'hC90FDAA2;

  // Base-2 logarithm in Q.30 by repeated squaring; evaluated at elaboration.
  function automatic logic [63:0] log2_q30(input logic [63:0] x);
    logic [63:0] m;
    logic [63:0] r;
    int          p;
    if (x == 64'd0) begin
      return 64'd0;
    end
    p = 63;
    while (p > 0 && !x[p]) begin
      p = p - 1;
    end
    m = (p >= 30) ? (x >> (p - 30)) : (x << (30 - p));
    r = 64'(p) << 30;
    for (int k = 29; k >= 0; k--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m    = m >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  // 7 - log2(pi) style constant part of the log density in Q.32.
  localparam logic [63:0] LOG2_PI_Q32 =
    (log2_q30(64'(PI_Q30)) - (64'd30 << 30)) << 2;
  localparam logic signed [LV_W-1:0] BASE_K = LV_W'((64'd7 << 32) - LOG2_PI_Q32);

  // Values from configuration; the user, not the block, keeps them held steady while items are in flight.
  typedef struct packed {
    logic signed [MEAN_W-1:0] mean_x;
    logic signed [MEAN_W-1:0] mean_y;
    logic signed [COV_W-1:0]  cov_xx;
    logic signed [COV_W-1:0]  cov_yy;
    logic signed [COV_W:0]    cov_sum;
    logic [DET_W-1:0]         det;
    logic signed [LV_W-1:0]   base;
    logic                     bad;
  } cfg_t;

endpackage

[src/g2l_cfg.sv]
// ----------------------------------------------------------------------------
// g2l_cfg
// Configuration registers and a sequencer that derives the determinant,
// its logarithm and the constant part of the log density.
// ----------------------------------------------------------------------------
`include "gaussian_2d_likelihood_assert.svh"

module g2l_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [g2l_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [g2l_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               busy,
  output g2l_pkg::cfg_t                      cfg
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL_A = 3'd1;
  localparam logic [2:0] S_MUL_B = 3'd2;
  localparam logic [2:0] S_DET   = 3'd3;
  localparam logic [2:0] S_NORM  = 3'd4;
  localparam logic [2:0] S_SQR   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]                         state_r;
  logic signed [g2l_pkg::MEAN_W-1:0]  mean_x_r, mean_y_r;
  logic signed [g2l_pkg::COV_W-1:0]   cov_xx_r, cov_xy_r, cov_yx_r, cov_yy_r;
  logic signed [63:0]                 a_r, b_r;
  logic signed [g2l_pkg::COV_W:0]     csum_r;
  logic [g2l_pkg::DET_W-1:0]          det_r;
  logic                               bad_r;
  logic [63:0]                        norm_r;
  logic [5:0]                         pos_r;
  logic [30:0]                        mant_r;
  logic [29:0]                        frac_r;
  logic [4:0]                         cnt_r;
  logic signed [g2l_pkg::LV_W-1:0]    base_r;

  logic [63:0] det_full;
  logic [61:0] sq_full;
  logic [31:0] sq_hi;

  assign det_full = a_r - b_r;
  assign sq_full  = mant_r * mant_r;
  assign sq_hi    = sq_full[61:30];

  // Register writes restart the sequencer; otherwise it steps on its own.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mean_x_r <= '0;
      mean_y_r <= '0;
      cov_xx_r <= 32'sd256;
      cov_xy_r <= '0;
      cov_yx_r <= '0;
      cov_yy_r <= 32'sd256;
      bad_r    <= 1'b0;
      state_r  <= S_MUL_A;
    end else if (cfg_we) begin
      case (cfg_index)
        g2l_pkg::REG_MEAN_X: mean_x_r <= cfg_wdata[g2l_pkg::MEAN_W-1:0];
        g2l_pkg::REG_MEAN_Y: mean_y_r <= cfg_wdata[g2l_pkg::MEAN_W-1:0];
        g2l_pkg::REG_COV_XX: cov_xx_r <= cfg_wdata[g2l_pkg::COV_W-1:0];
        g2l_pkg::REG_COV_XY: cov_xy_r <= cfg_wdata[g2l_pkg::COV_W-1:0];
        g2l_pkg::REG_COV_YX: cov_yx_r <= cfg_wdata[g2l_pkg::COV_W-1:0];
        g2l_pkg::REG_COV_YY: cov_yy_r <= cfg_wdata[g2l_pkg::COV_W-1:0];
        default: begin
        end
      endcase
      state_r <= S_MUL_A;
    end else begin
      case (state_r)
        S_MUL_A: begin
          a_r     <= cov_xx_r * cov_yy_r;
          state_r <= S_MUL_B;
        end
        S_MUL_B: begin
          b_r     <= cov_xy_r * cov_yx_r;
          csum_r  <= 33'(cov_xy_r) + 33'(cov_yx_r);
          state_r <= S_DET;
        end
        S_DET: begin
          if (a_r <= b_r) begin
            bad_r   <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            bad_r   <= 1'b0;
            det_r   <= det_full[g2l_pkg::DET_W-1:0];
            norm_r  <= det_full;
            pos_r   <= 6'd63;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          // Walk the leading one up to the top bit to find its position.
          if (norm_r[63]) begin
            mant_r  <= norm_r[63:33];
            frac_r  <= '0;
            cnt_r   <= 5'd29;
            state_r <= S_SQR;
          end else begin
            norm_r <= norm_r << 1;
            pos_r  <= pos_r - 6'd1;
          end
        end
        S_SQR: begin
          // One fraction bit of the logarithm per squaring.
          mant_r <= sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
          frac_r <= {frac_r[28:0], sq_hi[31]};
          if (cnt_r == 5'd0) begin
            state_r <= S_FIN;
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        S_FIN: begin
          base_r  <= g2l_pkg::BASE_K - g2l_pkg::LV_W'({pos_r, frac_r, 1'b0});
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cfg.mean_x  = mean_x_r;
    cfg.mean_y  = mean_y_r;
    cfg.cov_xx  = cov_xx_r;
    cfg.cov_yy  = cov_yy_r;
    cfg.cov_sum = csum_r;
    cfg.det     = det_r;
    cfg.base    = base_r;
    cfg.bad     = bad_r;
  end

  `G2L_ASSERT_NEXT(a_write_restarts, cfg_we, busy, "write did not restart the sequencer")
  `G2L_ASSERT_SAME(a_busy_from_write, $rose(busy), $past(cfg_we), "busy rose without a write")
  `G2L_ASSERT_SAME(a_det_nonzero, (state_r == S_IDLE) && !bad_r, det_r != '0, "zero det")

endmodule

[src/g2l_quad.sv]
// ----------------------------------------------------------------------------
// g2l_quad
// Five-stage pipeline forming the quadratic form numerator and its magnitude.
// ----------------------------------------------------------------------------
module g2l_quad (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic signed [g2l_pkg::MEAN_W-1:0]  in_sample_x,
  input  logic signed [g2l_pkg::MEAN_W-1:0]  in_sample_y,
  input  g2l_pkg::cfg_t                      cfg,
  output logic                               out_valid,
  output logic [g2l_pkg::MAG_W-1:0]          out_mag,
  output logic                               out_neg
);

  logic [4:0]          vld_r;
  logic signed [16:0]  dx_r, dy_r;
  logic signed [33:0]  pxx_r, pxy_r, pyy_r;
  logic signed [65:0]  t1_r, t3_r;
  logic signed [66:0]  t2_r;
  logic signed [67:0]  n_r;
  logic [g2l_pkg::MAG_W-1:0] mag_r;
  logic                neg_r;

  // Valid bits travel beside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  // Offsets, squares and cross product, covariance weighting, sum, magnitude.
  always_ff @(posedge clk) begin
    dx_r  <= 17'(in_sample_x) - 17'(cfg.mean_x);
    dy_r  <= 17'(in_sample_y) - 17'(cfg.mean_y);
    pxx_r <= dx_r * dx_r;
    pxy_r <= dx_r * dy_r;
    pyy_r <= dy_r * dy_r;
    t1_r  <= pxx_r * cfg.cov_yy;
    t2_r  <= pxy_r * cfg.cov_sum;
    t3_r  <= pyy_r * cfg.cov_xx;
    n_r   <= 68'(t1_r) - 68'(t2_r) + 68'(t3_r);
    neg_r <= n_r[67];
    mag_r <= n_r[67] ? g2l_pkg::MAG_W'(-n_r) : g2l_pkg::MAG_W'(n_r);
  end

  assign out_valid = vld_r[4];
  assign out_mag   = mag_r;
  assign out_neg   = neg_r;

endmodule

[src/g2l_div.sv]
// ----------------------------------------------------------------------------
// g2l_div
// Pipelined restoring divider, one quotient bit per stage, giving the
// saturated quotient magnitude * 2^32 / det in Q.32.
// ----------------------------------------------------------------------------
module g2l_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [g2l_pkg::MAG_W-1:0]     in_mag,
  input  logic                          in_neg,
  input  logic [g2l_pkg::DET_W-1:0]     det,
  output logic                          out_valid,
  output logic [g2l_pkg::QUO_W-1:0]     out_quo,
  output logic                          out_neg
);

  localparam int NS  = g2l_pkg::DIV_STEPS;
  localparam int RW  = g2l_pkg::REM_W;

  logic [RW-1:0] rem_r [0:NS];
  logic [NS-1:0] quo_r [0:NS];
  logic [NS:0]   vld_r;
  logic [NS:0]   neg_r;
  logic [NS:0]   cap_r;

  // Entry stage: a quotient at or above the cap needs no further steps.
  always_ff @(posedge clk) begin
    rem_r[0] <= RW'(in_mag);
    quo_r[0] <= '0;
    neg_r[0] <= in_neg;
    cap_r[0] <= (RW'(in_mag) >= {det, {g2l_pkg::DIV_INT_STEPS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[NS-1:0], in_valid};
    end
  end

  for (genvar i = 0; i < NS; i++) begin : g_step
    logic [RW-1:0] trial;
    logic [RW-1:0] divs;
    logic          ge;

    // Integer bits compare against shifted det, fraction bits shift in zeros.
    if (i < g2l_pkg::DIV_INT_STEPS) begin : g_int
      assign trial = rem_r[i];
      assign divs  = RW'(det) << (g2l_pkg::DIV_INT_STEPS - 1 - i);
    end else begin : g_frac
      assign trial = rem_r[i] << 1;
      assign divs  = RW'(det);
    end

    assign ge = (trial >= divs);

    always_ff @(posedge clk) begin
      rem_r[i+1]   <= ge ? (trial - divs) : trial;
      quo_r[i+1]   <= {quo_r[i][NS-2:0], ge};
      neg_r[i+1]   <= neg_r[i];
      cap_r[i+1]   <= cap_r[i];
    end
  end

  assign out_valid = vld_r[NS];
  assign out_neg   = neg_r[NS];
  assign out_quo   = cap_r[NS] ? (g2l_pkg::QUO_W'(1) << NS) : g2l_pkg::QUO_W'(quo_r[NS]);

endmodule

[src/g2l_exp.sv]
// ----------------------------------------------------------------------------
// g2l_exp
// Log-domain combination and 2^x evaluation: scales the quotient by
// log2(e)/2, forms the exponent, sums the series and rounds the density.
// ----------------------------------------------------------------------------
module g2l_exp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [g2l_pkg::QUO_W-1:0]       in_quo,
  input  logic                            in_neg,
  input  logic signed [g2l_pkg::LV_W-1:0] base,
  input  logic                            bad,
  output logic                            out_valid,
  output logic [g2l_pkg::DENS_W-1:0]      out_density,
  output logic                            out_status
);

  localparam int NT = g2l_pkg::TAYLOR_TERMS;
  localparam int NL = 3 * NT;

  typedef struct packed {
    logic [31:0] y;
    logic [31:0] v;
    logic [31:0] q0;
    logic [31:0] term;
    logic [33:0] sum;
    logic [5:0]  sh;
    logic        sat;
    logic        far;
  } ts_t;

  logic        v1_r, v2_r, v3_r;
  logic [42:0] qi_r;
  logic [31:0] qf_r;
  logic        neg1_r;
  logic signed [g2l_pkg::LV_W-1:0] lv_r;
  logic [31:0] f_r;
  logic [5:0]  sh3_r;
  logic        sat3_r, far3_r;
  ts_t         st_r [0:NL];
  logic [NL:0] tv_r;
  logic        out_valid_r, out_status_r;
  logic [g2l_pkg::DENS_W-1:0] dens_r;

  logic [63:0] qf_prod;
  logic [43:0] qterm;
  logic signed [g2l_pkg::LV_W-1:0] qt_s;
  logic [g2l_pkg::LV_W-1:0] e_abs;
  logic [16:0] sh_full;
  logic [63:0] y_prod;
  logic [40:0] rnd;
  logic [40:0] shv;

  // Valid chain through all stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      tv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      tv_r        <= {tv_r[NL-1:0], v3_r};
      out_valid_r <= tv_r[NL];
    end
  end

  assign qf_prod = 64'(in_quo[31:0]) * 64'(g2l_pkg::HALF_LOG2E_Q32);
  assign qterm   = 44'(qi_r) + 44'(qf_r);
  assign qt_s    = signed'(g2l_pkg::LV_W'(qterm));
  assign e_abs   = -lv_r;
  assign sh_full = 17'(e_abs[47:32]) + 17'(e_abs[31:0] != 32'd0);
  assign y_prod  = 64'(f_r) * 64'(g2l_pkg::LN2_Q32);

  // Quotient scaling, exponent, and split into shift and fraction.
  // The far flag only applies to a negative exponent.
  always_ff @(posedge clk) begin
    qi_r   <= in_quo[42:32] * g2l_pkg::HALF_LOG2E_Q32;
    qf_r   <= qf_prod[63:32];
    neg1_r <= in_neg;
    lv_r   <= neg1_r ? (base + qt_s) : (base - qt_s);
    sat3_r <= !lv_r[g2l_pkg::LV_W-1];
    far3_r <= lv_r[g2l_pkg::LV_W-1] && (sh_full > 17'(g2l_pkg::SH_MAX));
    sh3_r  <= sh_full[5:0];
    f_r    <= -e_abs[31:0];
  end

  // Series input: y = f * ln2, sum starts at one.
  always_ff @(posedge clk) begin
    st_r[0].y    <= y_prod[63:32];
    st_r[0].v    <= '0;
    st_r[0].q0   <= '0;
    st_r[0].term <= '0;
    st_r[0].sum  <= 34'(1) << 32;
    st_r[0].sh   <= sh3_r;
    st_r[0].sat  <= sat3_r;
    st_r[0].far  <= far3_r;
  end

  // Each series term takes three stages: product, reciprocal, correction.
  for (genvar k = 1; k <= NT; k++) begin : g_term
    localparam int K  = k;
    localparam int IA = 3 * k - 2;
    localparam int IB = 3 * k - 1;
    localparam int IC = 3 * k;
    localparam logic [35:0] RECIP = 36'((64'd1 << g2l_pkg::RECIP_SHIFT) / K);

    logic [63:0] vprod;
    logic [67:0] qprod;
    logic [36:0] kq;
    logic [36:0] rem;
    logic [31:0] tnext;
    ts_t         sa_nxt, sb_nxt, sc_nxt;

    if (K == 1) begin : g_first
      assign vprod = {st_r[IA-1].y, 32'd0};
    end else begin : g_rest
      assign vprod = 64'(st_r[IA-1].term) * 64'(st_r[IA-1].y);
    end

    assign qprod = 68'(st_r[IB-1].v) * 68'(RECIP);
    assign kq    = 37'(st_r[IC-1].q0) * 37'(K);
    assign rem   = 37'(st_r[IC-1].v) - kq;
    assign tnext = (rem >= 37'(K)) ? (st_r[IC-1].q0 + 32'd1) : st_r[IC-1].q0;

    // Stage contents with the field that each stage produces.
    always_comb begin
      sa_nxt      = st_r[IA-1];
      sa_nxt.v    = vprod[63:32];
      sb_nxt      = st_r[IB-1];
      sb_nxt.q0   = qprod[g2l_pkg::RECIP_SHIFT+31:g2l_pkg::RECIP_SHIFT];
      sc_nxt      = st_r[IC-1];
      sc_nxt.term = tnext;
      sc_nxt.sum  = st_r[IC-1].sum + 34'(tnext);
    end

    always_ff @(posedge clk) begin
      st_r[IA] <= sa_nxt;
    end

    always_ff @(posedge clk) begin
      st_r[IB] <= sb_nxt;
    end

    always_ff @(posedge clk) begin
      st_r[IC] <= sc_nxt;
    end
  end

  assign rnd = 41'(st_r[NL].sum) + (41'd1 << (st_r[NL].sh - 6'd1));
  assign shv = rnd >> st_r[NL].sh;

  // Final rounding shift, saturation and status.
  always_ff @(posedge clk) begin
    out_status_r <= bad;
    if (bad || st_r[NL].far) begin
      dens_r <= '0;
    end else if (st_r[NL].sat || (shv > 41'(32'hFFFFFFFF))) begin
      dens_r <= '1;
    end else begin
      dens_r <= shv[31:0];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_density = dens_r;
  assign out_status  = out_status_r;

endmodule

[src/gaussian_2d_likelihood.sv]
// Throughput: one sample per cycle while busy is low; the datapath is a fixed pipeline.
// After reset and after every register write, busy stays high while the
// determinant and its log2 are derived (one normalizing shift, then one
// squaring, per cycle).
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// gaussian_2d_likelihood
// Bivariate Gaussian density of a 2-D sample under one configured component.
// ----------------------------------------------------------------------------
`include "gaussian_2d_likelihood_assert.svh"

module gaussian_2d_likelihood (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [g2l_pkg::MEAN_W-1:0]  in_sample_x,
  input  logic signed [g2l_pkg::MEAN_W-1:0]  in_sample_y,
  input  logic                               cfg_we,
  input  logic [g2l_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [g2l_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                               out_valid,
  output logic [g2l_pkg::DENS_W-1:0]         out_density,
  output logic                               out_status
);

  g2l_pkg::cfg_t               cfg;
  logic                        accept;
  logic                        q_valid, q_neg, d_valid, d_neg;
  logic [g2l_pkg::MAG_W-1:0]   q_mag;
  logic [g2l_pkg::QUO_W-1:0]   d_quo;

  // A beat enters when start is seen while the sequencer is done.
  assign accept = start && !busy;

  g2l_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .cfg       (cfg)
  );

  g2l_quad u_quad (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (accept),
    .in_sample_x (in_sample_x),
    .in_sample_y (in_sample_y),
    .cfg         (cfg),
    .out_valid   (q_valid),
    .out_mag     (q_mag),
    .out_neg     (q_neg)
  );

  g2l_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_mag    (q_mag),
    .in_neg    (q_neg),
    .det       (cfg.det),
    .out_valid (d_valid),
    .out_quo   (d_quo),
    .out_neg   (d_neg)
  );

  g2l_exp u_exp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (d_valid),
    .in_quo      (d_quo),
    .in_neg      (d_neg),
    .base        (cfg.base),
    .bad         (cfg.bad),
    .out_valid   (out_valid),
    .out_density (out_density),
    .out_status  (out_status)
  );

  `G2L_ASSERT_SAME(a_bad_zero, out_valid && out_status, out_density == '0, "bad det, nonzero")

endmodule
